// ===== rtl/core/spq_pkg.sv =====
// Shared types, constants and index helpers for the sorted priority queue.
package spq_pkg;

  // Queue capacity and derived widths
  localparam int DEPTH = 32;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int OCC_W = 6;

  // Operation kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_REMOVED  = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // Command transfer
  typedef struct packed {
    logic               kind;
    logic signed [31:0] item_value;
    logic        [7:0]  priority_value;
  } cmd_t;

  // Result transfer
  typedef struct packed {
    logic        [1:0]       status;
    logic signed [31:0]      removed_item;
    logic        [OCC_W-1:0] occupancy;
  } res_t;

  // One stored entry
  typedef struct packed {
    logic signed [31:0] item;
    logic        [7:0]  prio;
  } entry_t;

  localparam int EW = $bits(entry_t);

  // Store write request
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    entry_t        data;
  } wr_req_t;

  // Circular index step forward
  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] idx);
    logic [AW-1:0] r;
    if (idx == AW'(DEPTH - 1)) r = '0;
    else                       r = idx + AW'(1);
    return r;
  endfunction

  // Circular index step back
  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] idx);
    logic [AW-1:0] r;
    if (idx == '0) r = AW'(DEPTH - 1);
    else           r = idx - AW'(1);
    return r;
  endfunction

endpackage

// ===== rtl/core/spq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/spq_seq.sv =====
// Sequencer: circular pointers, insertion walk with the shared priority compare.
module spq_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        acc,
  input  spq_pkg::cmd_t               cmd,
  output logic                        busy,
  output spq_pkg::wr_req_t            wr,
  output logic [spq_pkg::AW-1:0]      raddr,
  input  logic [spq_pkg::EW-1:0]      rdata,
  output logic                        fin,
  output spq_pkg::res_t               res
);
  import spq_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SHIFT = 2'd1;
  localparam logic [1:0] S_PLACE = 2'd2;
  localparam logic [1:0] S_POP   = 2'd3;

  logic [1:0]    state, state_next;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [AW-1:0] wp, wp_next;
  logic [AW-1:0] rp, rp_next;
  entry_t        new_ent, new_ent_next;
  entry_t        rd_ent;
  logic          ge;

  assign rd_ent = entry_t'(rdata);
  // Shared compare: stored entry stays ahead only if strictly smaller
  assign ge     = (rd_ent.prio >= new_ent.prio);
  assign busy   = (state != S_IDLE);

  // Next-state and datapath control
  always_comb begin
    state_next   = state;
    head_next    = head;
    tail_next    = tail;
    count_next   = count;
    pos_next     = pos;
    wp_next      = wp;
    rp_next      = rp;
    new_ent_next = new_ent;
    wr.en        = 1'b0;
    wr.addr      = wp;
    wr.data      = new_ent;
    raddr        = rp;
    fin          = 1'b0;
    res          = '0;

    case (state)
      S_IDLE: begin
        if (acc) begin
          if (cmd.kind == KIND_INSERT) begin
            if (count == CW'(DEPTH)) begin
              fin           = 1'b1;
              res.status    = ST_FULL;
              res.occupancy = OCC_W'(count);
            end else if (count == '0) begin
              wr.en         = 1'b1;
              wr.addr       = tail;
              wr.data.item  = cmd.item_value;
              wr.data.prio  = cmd.priority_value;
              tail_next     = idx_inc(tail);
              count_next    = count + CW'(1);
              fin           = 1'b1;
              res.status    = ST_INSERTED;
              res.occupancy = OCC_W'(count_next);
            end else begin
              raddr             = idx_dec(tail);
              wp_next           = tail;
              rp_next           = idx_dec(tail);
              pos_next          = count;
              new_ent_next.item = cmd.item_value;
              new_ent_next.prio = cmd.priority_value;
              state_next        = S_SHIFT;
            end
          end else begin
            if (count == '0) begin
              fin           = 1'b1;
              res.status    = ST_EMPTY;
              res.occupancy = '0;
            end else begin
              raddr      = head;
              state_next = S_POP;
            end
          end
        end
      end

      // Walk towards the head, moving each entry up one place
      S_SHIFT: begin
        if (ge) begin
          wr.en    = 1'b1;
          wr.addr  = wp;
          wr.data  = rd_ent;
          wp_next  = rp;
          rp_next  = idx_dec(rp);
          raddr    = idx_dec(rp);
          pos_next = pos - CW'(1);
          if (pos == CW'(1)) begin
            state_next = S_PLACE;
          end
        end else begin
          wr.en         = 1'b1;
          wr.addr       = wp;
          wr.data       = new_ent;
          tail_next     = idx_inc(tail);
          count_next    = count + CW'(1);
          fin           = 1'b1;
          res.status    = ST_INSERTED;
          res.occupancy = OCC_W'(count_next);
          state_next    = S_IDLE;
        end
      end

      // New entry goes to the head
      S_PLACE: begin
        wr.en         = 1'b1;
        wr.addr       = wp;
        wr.data       = new_ent;
        tail_next     = idx_inc(tail);
        count_next    = count + CW'(1);
        fin           = 1'b1;
        res.status    = ST_INSERTED;
        res.occupancy = OCC_W'(count_next);
        state_next    = S_IDLE;
      end

      // Head entry read back, drop it
      S_POP: begin
        head_next        = idx_inc(head);
        count_next       = count - CW'(1);
        fin              = 1'b1;
        res.status       = ST_REMOVED;
        res.removed_item = rd_ent.item;
        res.occupancy    = OCC_W'(count_next);
        state_next       = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    pos     <= pos_next;
    wp      <= wp_next;
    rp      <= rp_next;
    new_ent <= new_ent_next;
  end

endmodule

// ===== rtl/core/sorted_priority_queue_core.sv =====
// Top level of the sorted priority queue: store, sequencer and result register.
//
// Command channel: a transfer takes place at a rising edge with start high and
// busy low; cmd carries kind (insert or remove), item_value and priority_value.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver takes it at the end of that cycle and cannot stall it.
// Entries live in a circular RAM between head and tail pointers, kept sorted by
// priority number; equal numbers put the newer entry ahead.
// Timing, counted from the accepting edge:
//   insert into empty or full queue, remove from empty queue: done next cycle,
//   busy stays low.
//   remove: busy during the RAM read of the head (S_POP), done in the cycle after.
//   insert moving n entries: busy in S_SHIFT, then S_PLACE if all move; one RAM
//   read/write and one priority compare per cycle, done in the cycle after.
// A new command can be accepted while done is high; at most DEPTH-1 entries
// move on an insert.
// Reset (synchronous): queue empty, sequencer idle, done low. RAM contents are
// left alone; only entries between head and tail are ever read.
module sorted_priority_queue_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::cmd_t cmd,
  output logic          done,
  output spq_pkg::res_t result
);
  import spq_pkg::*;

  logic                acc;
  wr_req_t             wr;
  logic [AW-1:0]       raddr;
  logic [EW-1:0]       rdata;
  logic                fin;
  res_t                res;

  assign acc = start && !busy;

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  spq_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .cmd   (cmd),
    .busy  (busy),
    .wr    (wr),
    .raddr (raddr),
    .rdata (rdata),
    .fin   (fin),
    .res   (res)
  );

  // Result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fin) begin
      result <= res;
    end
  end

endmodule

// ===== rtl/core/spq_chk.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_chk (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input spq_pkg::cmd_t cmd,
  input logic          done,
  input spq_pkg::res_t result
);
  import spq_pkg::*;

  // An accepted command either keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted command neither busy nor answered");

  // A result is only shown once the sequencer is idle again
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Removed item is zero unless something was removed
  a_item_zero: assert property (@(posedge clk) disable iff (rst)
    done |-> (result.status == ST_REMOVED || result.removed_item == '0))
    else $error("removed item not zero");

  // Empty answer leaves no entries; a rejected insert means a full queue
  a_empty_occ: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_EMPTY) |-> (result.occupancy == '0))
    else $error("empty status with entries held");

  a_full_occ: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == ST_FULL) |-> (result.occupancy == OCC_W'(DEPTH)))
    else $error("full status with spare room");

endmodule

bind sorted_priority_queue_core spq_chk u_chk (.*);

// ===== test/tb_sorted_priority_queue_core.sv =====
// Self-checking testbench for the sorted priority queue core.
`timescale 1ns / 1ps

module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int BLOCK        = 40;
  localparam int CYCLE_LIMIT  = 200000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  cmd_t cmd;
  logic done;
  res_t result;

  sorted_priority_queue_core u_top (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // Shadow copy of the queue contents, head at index 0
  entry_t sorted_entries [DEPTH];
  int     held;
  int     peak_held;

  // Results still owed by the core, oldest first
  res_t   awaited_results [$];

  int fails;
  int n_inserted;
  int n_rejected;
  int n_removed;
  int n_empty;
  int n_checked;

  // Directed stimulus table
  typedef struct {
    cmd_t c;
    bit   typed;
    res_t want;
  } dir_row_t;

  dir_row_t dir_rows [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run guard
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("FAIL");
    $finish;
  end

  // Applies one command to the shadow queue and returns the result it owes
  function automatic res_t next_queue_result(input cmd_t c);
    res_t r;
    int   pos;
    int   i;
    r = '0;
    if (c.kind == KIND_INSERT) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        // new entry lands behind strictly smaller priority numbers only
        pos = held;
        while (pos > 0 && sorted_entries[pos-1].prio >= c.priority_value) pos--;
        for (i = held; i > pos; i--) sorted_entries[i] = sorted_entries[i-1];
        sorted_entries[pos].item = c.item_value;
        sorted_entries[pos].prio = c.priority_value;
        held++;
        r.status = ST_INSERTED;
      end
    end else begin
      if (held == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.removed_item = sorted_entries[0].item;
        for (i = 1; i < held; i++) sorted_entries[i-1] = sorted_entries[i];
        held--;
        r.status = ST_REMOVED;
      end
    end
    r.occupancy = held[OCC_W-1:0];
    return r;
  endfunction

  // Random command; priorities lean towards ties and extremes
  function automatic cmd_t random_cmd(input int insert_pct);
    cmd_t c;
    c.kind = ($urandom_range(99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
    case ($urandom_range(7))
      0:       c.item_value = 32'h7FFF_FFFF;
      1:       c.item_value = 32'h8000_0000;
      2:       c.item_value = '0;
      3:       c.item_value = '1;
      default: c.item_value = $urandom;
    endcase
    case ($urandom_range(5))
      0, 1:    c.priority_value = 8'($urandom_range(3));
      2:       c.priority_value = $urandom_range(1) ? 8'hFF : 8'h00;
      default: c.priority_value = 8'($urandom_range(255));
    endcase
    return c;
  endfunction

  function automatic void add_row(input logic kind, input logic [31:0] item,
                                  input logic [7:0] prio, input bit typed,
                                  input logic [1:0] st, input logic [31:0] rem,
                                  input int occ);
    dir_row_t row;
    row.c.kind                = kind;
    row.c.item_value          = item;
    row.c.priority_value      = prio;
    row.typed                 = typed;
    row.want.status           = st;
    row.want.removed_item     = rem;
    row.want.occupancy        = occ[OCC_W-1:0];
    dir_rows.push_back(row);
  endfunction

  // One command transfer, after an optional idle gap
  task automatic issue(input cmd_t c, input int gap, input bit typed, input res_t want);
    res_t predicted;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
      cmd   <= random_cmd(50);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd   <= c;
    // busy only moves on a rising edge, so it is stable here
    while (busy) @(negedge clk);
    predicted = next_queue_result(c);
    if (held > peak_held) peak_held = held;
    case (predicted.status)
      ST_INSERTED: n_inserted++;
      ST_FULL:     n_rejected++;
      ST_REMOVED:  n_removed++;
      default:     n_empty++;
    endcase
    awaited_results.push_back(typed ? want : predicted);
    @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    res_t exp_res;
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result transfer with nothing outstanding: status %0d", result.status);
        fails++;
      end else begin
        exp_res = awaited_results.pop_front();
        n_checked++;
        if (result.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, result.status);
          fails++;
        end
        if (result.removed_item !== exp_res.removed_item) begin
          $error("removed_item: expected %0d, got %0d",
                 exp_res.removed_item, result.removed_item);
          fails++;
        end
        if (result.occupancy !== exp_res.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_res.occupancy, result.occupancy);
          fails++;
        end
      end
    end
  end

  // Stimulus
  initial begin
    int   n;
    int   gap;
    int   idle_pct;
    int   insert_pct;
    int   phase;
    res_t no_res;

    rst        = 1'b1;
    start      = 1'b0;
    cmd        = '0;
    held       = 0;
    peak_held  = 0;
    fails      = 0;
    n_inserted = 0;
    n_rejected = 0;
    n_removed  = 0;
    n_empty    = 0;
    n_checked  = 0;
    no_res     = '0;
    for (n = 0; n < DEPTH; n++) sorted_entries[n] = '0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // remove from empty, then extremes of item and priority
    add_row(KIND_REMOVE, 32'h0,         8'h00, 1, ST_EMPTY,    32'h0,         0);
    add_row(KIND_INSERT, 32'h7FFF_FFFF, 8'hFF, 1, ST_INSERTED, 32'h0,         1);
    add_row(KIND_INSERT, 32'h8000_0000, 8'h00, 1, ST_INSERTED, 32'h0,         2);
    // equal priority number: newer entry goes ahead
    add_row(KIND_INSERT, 32'h0,         8'h00, 1, ST_INSERTED, 32'h0,         3);
    add_row(KIND_INSERT, 32'hFFFF_FFFF, 8'hFF, 1, ST_INSERTED, 32'h0,         4);
    add_row(KIND_REMOVE, 32'h1234_5678, 8'h55, 1, ST_REMOVED,  32'h0,         3);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 1, ST_REMOVED,  32'h8000_0000, 2);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 1, ST_REMOVED,  32'hFFFF_FFFF, 1);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 1, ST_REMOVED,  32'h7FFF_FFFF, 0);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 1, ST_EMPTY,    32'h0,         0);
    // ignored fields on a remove carry all ones
    add_row(KIND_REMOVE, 32'hFFFF_FFFF, 8'hFF, 1, ST_EMPTY,    32'h0,         0);
    // interleaved priorities, checked by prediction
    add_row(KIND_INSERT, 32'd5,         8'd10, 0, ST_INSERTED, 32'h0,         0);
    add_row(KIND_INSERT, 32'd6,         8'd5,  0, ST_INSERTED, 32'h0,         0);
    add_row(KIND_INSERT, 32'd7,         8'd20, 0, ST_INSERTED, 32'h0,         0);
    add_row(KIND_INSERT, 32'd8,         8'd10, 0, ST_INSERTED, 32'h0,         0);
    add_row(KIND_INSERT, 32'd9,         8'd5,  0, ST_INSERTED, 32'h0,         0);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 0, ST_REMOVED,  32'h0,         0);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 0, ST_REMOVED,  32'h0,         0);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 0, ST_REMOVED,  32'h0,         0);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 0, ST_REMOVED,  32'h0,         0);
    add_row(KIND_REMOVE, 32'h0,         8'h00, 0, ST_REMOVED,  32'h0,         0);

    foreach (dir_rows[i]) issue(dir_rows[i].c, 0, dir_rows[i].typed, dir_rows[i].want);

    // Random part: blocks that fill, drain or mix, across three idling phases
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % BLOCK == 0) begin
        phase = n * 3 / RANDOM_ITEMS;
        case (phase)
          0:       idle_pct = 0;
          1:       idle_pct = 63;
          default: idle_pct = 35;
        endcase
        // some blocks run back to back regardless of phase
        if ($urandom_range(3) == 0) idle_pct = 0;
        case ((n / BLOCK) % 5)
          0:       insert_pct = 100;
          1:       insert_pct = 50;
          2:       insert_pct = 0;
          3:       insert_pct = 80;
          default: insert_pct = 20;
        endcase
      end
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 5) : 0;
      issue(random_cmd(insert_pct), gap, 1'b0, no_res);
    end

    @(negedge clk);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);

    $display("Ran %0d commands: %0d inserted, %0d refused as full, %0d removed, %0d on empty",
             n_inserted + n_rejected + n_removed + n_empty,
             n_inserted, n_rejected, n_removed, n_empty);
    $display("Peak occupancy %0d of %0d, %0d results compared, %0d mismatches",
             peak_held, DEPTH, n_checked, fails);
    if (fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
